// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Expression that must never hold at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/u8d_pkg.sv =====
// Types and constants of the UTF-8 decoder.
`timescale 1ns / 1ps

package u8d_pkg;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SKIP  = 2'd1,
		ST_ERROR = 2'd2,
		ST_END   = 2'd3
	} status_t;

	localparam int CpWidth = 21;

	localparam logic [CpWidth-1:0] CP_MIN2   = 21'h000080;
	localparam logic [CpWidth-1:0] CP_MIN3   = 21'h000800;
	localparam logic [CpWidth-1:0] CP_SUR_LO = 21'h00d800;
	localparam logic [CpWidth-1:0] CP_SUR_HI = 21'h00dfff;
	localparam logic [CpWidth-1:0] CP_BOM    = 21'h00feff;
	localparam logic [CpWidth-1:0] CP_MIN4   = 21'h010000;
	localparam logic [CpWidth-1:0] CP_MAX    = 21'h10ffff;

	// Partial sequence carried between bytes.
	typedef struct packed {
		logic [1:0]         owed;
		logic [2:0]         len;
		logic [CpWidth-1:0] partial;
	} state_t;

	typedef struct packed {
		logic               valid;
		logic [CpWidth-1:0] code_point;
		status_t            status;
	} result_t;

endpackage

// ===== hw/rtl/u8d_if.sv =====
// Valid/ready channels for input bytes and decoded characters.
`timescale 1ns / 1ps

interface u8d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_last;

	modport source (output valid, output in_byte, output is_last, input ready);
	modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

interface u8d_char_if;
	import u8d_pkg::*;
	logic               valid;
	logic               ready;
	logic [CpWidth-1:0] code_point;
	status_t            status;

	modport source (output valid, output code_point, output status, input ready);
	modport sink (input valid, input code_point, input status, output ready);
endinterface

// ===== hw/rtl/utf8_to_codepoint_decoder.sv =====
// Top level of the UTF-8 to code point decoder.
`timescale 1ns / 1ps
//
// Channels: text carries one UTF-8 byte per beat (in_byte, plus is_last when
// the text length ends after that byte). chars carries one decoded character
// per beat: code_point and status (ok, skipped, error, end of text).
// Bytes that leave a sequence open produce no beat on chars.
//
// Path: input register, decode step, then result register driving chars.
// Throughput: one byte per cycle, set by the input register and the result
// register around a single decode step; chars stalls do not block text until
// both registers are full.
//
// Reset: arst_n clears the sequence state and both valid flags; the decoder
// then waits for a lead byte.
// Stall: while chars.ready is low, the result beat holds; one more byte may
// be taken into the input register, after which text.ready drops.
//
module utf8_to_codepoint_decoder (
	input logic       clk,
	input logic       arst_n,
	u8d_byte_if.sink   text,
	u8d_char_if.source chars
);
	import u8d_pkg::*;

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;
	state_t             state_q;
	state_t             state_nxt;
	result_t            res;
	logic               out_valid_q;
	logic [CpWidth-1:0] cp_q;
	status_t            status_q;
	logic               advance;

	assign advance    = valid_s1 && (!out_valid_q || chars.ready);
	assign text.ready = !valid_s1 || advance;

	u8d_step u_step (
		.cur     (state_q),
		.in_byte (byte_s1),
		.is_last (last_s1),
		.nxt     (state_nxt),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.in_byte;
			last_s1 <= text.is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (chars.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			cp_q     <= res.code_point;
			status_q <= res.status;
		end
	end

	assign chars.valid      = out_valid_q;
	assign chars.code_point = cp_q;
	assign chars.status     = status_q;

endmodule

// ===== hw/rtl/u8d_step.sv =====
// One decode step: sequence state and one byte in, next state and optional result out.
`timescale 1ns / 1ps

module u8d_step (
	input  u8d_pkg::state_t  cur,
	input  logic [7:0]       in_byte,
	input  logic             is_last,
	output u8d_pkg::state_t  nxt,
	output u8d_pkg::result_t res
);
	import u8d_pkg::*;

	logic [CpWidth-1:0] joined;
	logic [1:0]         owed_dec;
	status_t            cls;

	assign joined   = {cur.partial[CpWidth-7:0], in_byte[5:0]};
	assign owed_dec = cur.owed - 2'd1;

	always_comb begin
		cls = ST_OK;
		unique case (cur.len)
			3'd2: begin
				if (joined < CP_MIN2) cls = ST_SKIP;
			end
			3'd3: begin
				if (joined < CP_MIN3 || joined == CP_BOM ||
				    (joined >= CP_SUR_LO && joined <= CP_SUR_HI)) cls = ST_SKIP;
			end
			default: begin
				if (joined < CP_MIN4 || joined > CP_MAX) cls = ST_SKIP;
			end
		endcase
	end

	always_comb begin
		nxt = '0;
		res = '{valid: 1'b0, code_point: '0, status: ST_OK};
		if (cur.owed == 2'd0) begin
			if (in_byte == 8'h00) begin
				res.valid  = 1'b1;
				res.status = ST_END;
			end else if (!in_byte[7]) begin
				res.valid      = 1'b1;
				res.code_point = {{(CpWidth-8){1'b0}}, in_byte};
			end else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110 ||
			             in_byte[7:3] == 5'b11110) begin
				if (is_last) begin
					res.valid  = 1'b1;
					res.status = ST_ERROR;
				end else if (in_byte[7:5] == 3'b110) begin
					nxt.owed    = 2'd1;
					nxt.len     = 3'd2;
					nxt.partial = {{(CpWidth-5){1'b0}}, in_byte[4:0]};
				end else if (in_byte[7:4] == 4'b1110) begin
					nxt.owed    = 2'd2;
					nxt.len     = 3'd3;
					nxt.partial = {{(CpWidth-4){1'b0}}, in_byte[3:0]};
				end else begin
					nxt.owed    = 2'd3;
					nxt.len     = 3'd4;
					nxt.partial = {{(CpWidth-3){1'b0}}, in_byte[2:0]};
				end
			end else begin
				res.valid  = 1'b1;
				res.status = ST_ERROR;
			end
		end else if (in_byte[7:6] != 2'b10) begin
			res.valid  = 1'b1;
			res.status = ST_ERROR;
		end else if (owed_dec == 2'd0) begin
			res.valid      = 1'b1;
			res.code_point = joined;
			res.status     = cls;
		end else if (is_last) begin
			// sequence cut off before its final continuation byte
			res.valid  = 1'b1;
			res.status = ST_ERROR;
		end else begin
			nxt.owed    = owed_dec;
			nxt.len     = cur.len;
			nxt.partial = joined;
		end
	end

endmodule

// ===== hw/rtl/u8d_checker.sv =====
// Port-level checks of the UTF-8 decoder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8d_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        byte_valid,
	input logic                        byte_ready,
	input logic                        char_valid,
	input logic                        char_ready,
	input logic [u8d_pkg::CpWidth-1:0] code_point,
	input u8d_pkg::status_t            status
);
	import u8d_pkg::*;

	// a held result beat keeps its payload
	`ASSERT_PROP(a_char_hold, clk, arst_n, char_valid && !char_ready |=> char_valid && $stable(code_point) && $stable(status), "result beat changed while stalled")

	// error and end beats carry a zero code point
	`ASSERT_NEVER(a_zero_cp, clk, arst_n, char_valid && (status == ST_ERROR || status == ST_END) && code_point != '0, "nonzero code point on error or end")

	// ok characters are real scalar values
	`ASSERT_NEVER(a_ok_range, clk, arst_n, char_valid && status == ST_OK && (code_point == '0 || code_point > CP_MAX || (code_point >= CP_SUR_LO && code_point <= CP_SUR_HI)), "ok beat outside scalar range")

	// a result appearing on an idle output comes from a byte that went from the input register
	// straight into the result register, with no stall between
	`ASSERT_PROP(a_rise_src, clk, arst_n, $rose(char_valid) |-> $past(byte_valid && byte_ready, 2), "result beat without a byte behind it")

endmodule

bind utf8_to_codepoint_decoder u8d_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (text.valid),
	.byte_ready (text.ready),
	.char_valid (chars.valid),
	.char_ready (chars.ready),
	.code_point (chars.code_point),
	.status     (chars.status)
);
